FILE: rtl/core/jcp_pkg.sv
package jcp_pkg;

  // Number of characters in the packet tag
  localparam int unsigned TagLen = 8;

  // Command queue depth between front and back
  localparam int unsigned CmdDepth = 4;
  localparam int unsigned CmdPtrW  = $clog2(CmdDepth);

  // Result status codes
  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusBadTag   = 2'd1;
  localparam logic [1:0] StatusFewValue = 2'd2;

  // Byte codes seen on the wire
  localparam logic [7:0] ChOpen  = 8'h5B;  // '['
  localparam logic [7:0] ChClose = 8'h5D;  // ']'
  localparam logic [7:0] ChComma = 8'h2C;  // ','
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;

  typedef enum logic [1:0] {
    CMD_CHAR,
    CMD_SEP,
    CMD_CLOSE
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] ch;
  } cmd_t;

  // Expected tag text, one character per position
  function automatic logic [7:0] tag_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = 8'h6A;  // j
      3'd1:    c = 8'h6F;  // o
      3'd2:    c = 8'h79;  // y
      3'd3:    c = 8'h73;  // s
      3'd4:    c = 8'h74;  // t
      3'd5:    c = 8'h69;  // i
      3'd6:    c = 8'h63;  // c
      default: c = 8'h6B;  // k
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/jcp_front.sv
module jcp_front import jcp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_fire_i,
  input  logic [7:0] rx_byte_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  logic in_packet_q, in_packet_d;
  logic text_ended_q, text_ended_d;

  // Classify each transferred byte into a command or drop it
  always_comb begin
    in_packet_d  = in_packet_q;
    text_ended_d = text_ended_q;
    push_o       = 1'b0;
    cmd_o.kind   = CMD_CHAR;
    cmd_o.ch     = rx_byte_i;
    if (in_fire_i) begin
      priority if (!in_packet_q) begin
        if (rx_byte_i == ChOpen) begin
          in_packet_d  = 1'b1;
          text_ended_d = 1'b0;
        end
      end else if (rx_byte_i == ChClose) begin
        push_o       = 1'b1;
        cmd_o.kind   = CMD_CLOSE;
        in_packet_d  = 1'b0;
        text_ended_d = 1'b0;
      end else if (text_ended_q) begin
        push_o = 1'b0;
      end else if (rx_byte_i == ChNul) begin
        push_o       = 1'b1;
        cmd_o.kind   = CMD_SEP;
        text_ended_d = 1'b1;
      end else if (rx_byte_i == ChComma) begin
        push_o     = 1'b1;
        cmd_o.kind = CMD_SEP;
      end else begin
        push_o     = 1'b1;
        cmd_o.kind = CMD_CHAR;
      end
    end
  end

  // Hold framing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_packet_q  <= 1'b0;
      text_ended_q <= 1'b0;
    end else begin
      in_packet_q  <= in_packet_d;
      text_ended_q <= text_ended_d;
    end
  end

endmodule

FILE: rtl/core/jcp_cmd_fifo.sv
module jcp_cmd_fifo import jcp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic full_o,
  output logic empty_o
);

  cmd_t                 mem_q [CmdDepth];
  logic [CmdPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CmdPtrW:0]     count_q;

  assign full_o  = (count_q == (CmdPtrW+1)'(CmdDepth));
  assign empty_o = (count_q == '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  // Store commands
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

FILE: rtl/core/jcp_back.sv
module jcp_back import jcp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  cmd_t              cmd_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic signed [4:0] speed_target_o,
  output logic signed [4:0] turn_target_o,
  output logic [1:0]        packet_status_o
);

  localparam logic [1:0] PhSkip = 2'd0;
  localparam logic [1:0] PhNum  = 2'd1;
  localparam logic [1:0] PhDone = 2'd2;

  // Parse state
  logic [2:0] field_num_q, field_num_d;
  logic       has_chars_q, has_chars_d;
  logic [3:0] tag_pos_q, tag_pos_d;
  logic       tag_ok_q, tag_ok_d;
  logic [1:0] phase_q, phase_d;
  logic       neg_q, neg_d;
  logic [7:0] acc_q, acc_d;
  logic [7:0] lv_q, lv_d;
  logic [7:0] rh_q, rh_d;

  // Field close results
  logic [2:0] ef_field_num;
  logic       ef_tag_ok;
  logic [7:0] ef_lv, ef_rh, ef_val;

  // Result register
  logic              out_valid_q;
  logic signed [4:0] speed_q, turn_q;
  logic [1:0]        status_q;

  logic       out_free;
  logic       is_space, is_digit;
  logic [7:0] c;
  logic [7:0] abs_lv, abs_rh;
  logic [15:0] prod_s, prod_t;
  logic [4:0] q_s, q_t;
  logic signed [4:0] speed_d, turn_d;
  logic [1:0] status_d;

  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o    = !empty_i && ((cmd_i.kind != CMD_CLOSE) || out_free);
  assign c        = cmd_i.ch;
  assign is_space = (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  assign is_digit = (c >= ChZero) && (c <= ChNine);

  // Close the current field
  always_comb begin
    ef_field_num = field_num_q;
    ef_tag_ok    = tag_ok_q;
    ef_lv        = lv_q;
    ef_rh        = rh_q;
    ef_val       = neg_q ? (8'd0 - acc_q) : acc_q;
    if (has_chars_q) begin
      if (field_num_q == 3'd0) begin
        ef_tag_ok = tag_ok_q && (tag_pos_q == 4'(TagLen));
      end else if (field_num_q == 3'd2) begin
        ef_lv = ef_val;
      end else if (field_num_q == 3'd3) begin
        ef_rh = ef_val;
      end
      if (field_num_q != 3'd7) begin
        ef_field_num = field_num_q + 3'd1;
      end
    end
  end

  // Divide by 15 and 10 through reciprocal multiply, truncating toward zero
  always_comb begin
    abs_lv  = ef_lv[7] ? (8'd0 - ef_lv) : ef_lv;
    abs_rh  = ef_rh[7] ? (8'd0 - ef_rh) : ef_rh;
    prod_s  = 16'(abs_lv) * 16'd137;
    prod_t  = 16'(abs_rh) * 16'd205;
    q_s     = prod_s[15:11];
    q_t     = prod_t[15:11];
    speed_d = ef_lv[7] ? $signed(5'd0 - q_s) : $signed(q_s);
    turn_d  = ef_rh[7] ? $signed(5'd0 - q_t) : $signed(q_t);
    priority if ((ef_field_num == 3'd0) || !ef_tag_ok) begin
      status_d = StatusBadTag;
    end else if (ef_field_num < 3'd5) begin
      status_d = StatusFewValue;
    end else begin
      status_d = StatusOk;
    end
  end

  // Next parse state per command
  always_comb begin
    field_num_d = field_num_q;
    has_chars_d = has_chars_q;
    tag_pos_d   = tag_pos_q;
    tag_ok_d    = tag_ok_q;
    phase_d     = phase_q;
    neg_d       = neg_q;
    acc_d       = acc_q;
    lv_d        = lv_q;
    rh_d        = rh_q;
    if (pop_o) begin
      unique case (cmd_i.kind)
        CMD_CLOSE: begin
          field_num_d = '0;
          has_chars_d = 1'b0;
          tag_pos_d   = '0;
          tag_ok_d    = 1'b1;
          phase_d     = PhSkip;
          neg_d       = 1'b0;
          acc_d       = '0;
          lv_d        = '0;
          rh_d        = '0;
        end
        CMD_SEP: begin
          field_num_d = ef_field_num;
          tag_ok_d    = ef_tag_ok;
          lv_d        = ef_lv;
          rh_d        = ef_rh;
          has_chars_d = 1'b0;
          phase_d     = PhSkip;
          neg_d       = 1'b0;
          acc_d       = '0;
        end
        CMD_CHAR: begin
          has_chars_d = 1'b1;
          if (field_num_q == 3'd0) begin
            if (!tag_pos_q[3] && (c == tag_char(tag_pos_q[2:0]))) begin
              tag_pos_d = tag_pos_q + 4'd1;
            end else begin
              tag_ok_d = 1'b0;
            end
          end else begin
            priority if ((phase_q == PhSkip) && is_space) begin
              phase_d = PhSkip;
            end else if ((phase_q == PhSkip) && ((c == ChPlus) || (c == ChMinus))) begin
              neg_d   = (c == ChMinus);
              phase_d = PhNum;
            end else if ((phase_q == PhSkip) || (phase_q == PhNum)) begin
              if (is_digit) begin
                phase_d = PhNum;
                acc_d   = 8'(acc_q * 8'd10 + (c - ChZero));
              end else begin
                phase_d = PhDone;
              end
            end else begin
              phase_d = phase_q;
            end
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  // Hold parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_num_q <= '0;
      has_chars_q <= 1'b0;
      tag_pos_q   <= '0;
      tag_ok_q    <= 1'b1;
      phase_q     <= PhSkip;
      neg_q       <= 1'b0;
      acc_q       <= '0;
      lv_q        <= '0;
      rh_q        <= '0;
    end else begin
      field_num_q <= field_num_d;
      has_chars_q <= has_chars_d;
      tag_pos_q   <= tag_pos_d;
      tag_ok_q    <= tag_ok_d;
      phase_q     <= phase_d;
      neg_q       <= neg_d;
      acc_q       <= acc_d;
      lv_q        <= lv_d;
      rh_q        <= rh_d;
    end
  end

  // Result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o && (cmd_i.kind == CMD_CLOSE)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload, targets zero unless ok
  always_ff @(posedge clk_i) begin
    if (pop_o && (cmd_i.kind == CMD_CLOSE)) begin
      speed_q  <= (status_d == StatusOk) ? speed_d : 5'sd0;
      turn_q   <= (status_d == StatusOk) ? turn_d : 5'sd0;
      status_q <= status_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign speed_target_o  = speed_q;
  assign turn_target_o   = turn_q;
  assign packet_status_o = status_q;

endmodule

FILE: rtl/core/bracket_joystick_command_parser.sv
// A closing bracket is written into the command queue, then its result is registered.
// Throughput: one byte per cycle while the queue has room; the front classifies, the back parses one command a cycle.
// A four-entry command queue lets the front keep taking bytes while a result waits.
// Reset: rst_ni is asynchronous, active low; it clears framing, parse state and the queue.
module bracket_joystick_command_parser import jcp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [4:0] speed_target, [9:5] turn_target,
                                      // [11:10] packet_status, [15:12] zero
);

  logic              in_fire;
  logic              push, pop, full, empty;
  cmd_t              push_cmd, head_cmd;
  logic signed [4:0] speed_target, turn_target;
  logic [1:0]        packet_status;

  assign s_axis_tready = !full;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  jcp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_fire_i (in_fire),
    .rx_byte_i (s_axis_tdata),
    .push_o    (push),
    .cmd_o     (push_cmd)
  );

  jcp_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .full_o  (full),
    .empty_o (empty)
  );

  jcp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .cmd_i           (head_cmd),
    .pop_o           (pop),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .speed_target_o  (speed_target),
    .turn_target_o   (turn_target),
    .packet_status_o (packet_status)
  );

  assign m_axis_tdata = {4'd0, packet_status, turn_target, speed_target};

endmodule
